// ----- rtl/core/sfd_pkg.sv -----
// Shared types and constants of the SLIP frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

  // SLIP framing bytes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  // Decode status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_CUT = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  // Receiver modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_HUNT  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  localparam logic [15:0] MAX_RAW_LENGTH_RESET = 16'd256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic [1:0]  decode_status;
  } result_t;

endpackage

// ----- rtl/core/slip_frame_decoder_core.sv -----
// SLIP frame decoder top level: streaming decode with a registered, skid-buffered result.
`timescale 1ns / 1ps
//
// Usage:
//   in_*  : one item per raw event. in_tuser = operation (0 data byte, 1 arm),
//           in_tdata = received raw byte. Arm starts a hunt for the opening END.
//   out_* : decoded results. out_tuser = kind (0 payload byte, 1 frame end,
//           2 overflow). out_tdata carries payload_byte, payload_length and
//           decode_status.
//   cfg_* : writes max_raw_length (frame limit: max_raw_length - 1 raw bytes incl. both ENDs).
//           Write only while the block is idle; cfg_ready is always high.
// Output: each result is registered, in the skid register if the output register is stalled.
// Throughput: one item per cycle while in_tready is high; the mode and counter
//   update is a single registered pass per byte.
// Reset: receiver idle (needs an arm), counts cleared, max_raw_length = 256.
// Stall: while out_tready is low a second result is held in a skid register;
//   in_tready drops only when both the output and skid registers are full.
module slip_frame_decoder_core
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [23:8] payload_length,
                                  // [25:24] decode_status, [31:26] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // max_raw_length
);

  logic [15:0] max_len_r;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] raw_cnt_r, raw_cnt_nxt;
  logic [15:0] pay_cnt_r, pay_cnt_nxt;
  logic        esc_r, esc_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        out_valid_r;
  result_t     out_r;
  logic        skid_valid_r;
  result_t     skid_r;

  logic        in_fire, out_fire;
  logic        has_res;
  result_t     res;
  logic [15:0] limit;
  logic [7:0]  dec_byte;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign limit = (max_len_r != 16'd0) ? max_len_r - 16'd1 : 16'd0;

  always_comb begin
    mode_nxt    = mode_r;
    raw_cnt_nxt = raw_cnt_r;
    pay_cnt_nxt = pay_cnt_r;
    esc_nxt     = esc_r;
    err_nxt     = err_r;
    has_res     = 1'b0;
    res         = '0;
    dec_byte    = in_tdata;
    if (in_tuser == OP_ARM) begin
      mode_nxt    = MODE_HUNT;
      raw_cnt_nxt = '0;
      pay_cnt_nxt = '0;
      esc_nxt     = 1'b0;
      err_nxt     = STATUS_OK;
    end else if (mode_r == MODE_HUNT) begin
      if (in_tdata == SLIP_END) begin
        mode_nxt    = MODE_FRAME;
        raw_cnt_nxt = 16'd1;
        pay_cnt_nxt = '0;
        esc_nxt     = 1'b0;
        err_nxt     = STATUS_OK;
      end
    end else if (mode_r == MODE_FRAME) begin
      if (raw_cnt_r >= limit) begin
        // drop the byte, stay in the frame
        has_res  = 1'b1;
        res.kind = KIND_OVERFLOW;
      end else begin
        raw_cnt_nxt = raw_cnt_r + 16'd1;
        if (in_tdata == SLIP_END) begin
          has_res            = 1'b1;
          res.kind           = KIND_END;
          res.payload_length = pay_cnt_r;
          res.decode_status  = (err_r == STATUS_OK && esc_r) ? STATUS_CUT : err_r;
          mode_nxt           = MODE_IDLE;
          esc_nxt            = 1'b0;
        end else if (err_r == STATUS_OK) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            case (in_tdata)
              SLIP_ESC_END: dec_byte = SLIP_END;
              SLIP_ESC_ESC: dec_byte = SLIP_ESC;
              default:      err_nxt  = STATUS_BAD;
            endcase
            if (in_tdata == SLIP_ESC_END || in_tdata == SLIP_ESC_ESC) begin
              has_res     = 1'b1;
              pay_cnt_nxt = pay_cnt_r + 16'd1;
            end
          end else if (in_tdata == SLIP_ESC) begin
            esc_nxt = 1'b1;
          end else begin
            has_res     = 1'b1;
            pay_cnt_nxt = pay_cnt_r + 16'd1;
          end
          if (has_res) begin
            res.kind         = KIND_BYTE;
            res.payload_byte = dec_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_RAW_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      raw_cnt_r <= '0;
      pay_cnt_r <= '0;
      esc_r     <= 1'b0;
      err_r     <= STATUS_OK;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      raw_cnt_r <= raw_cnt_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      esc_r     <= esc_nxt;
      err_r     <= err_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && has_res) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire && has_res) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {6'd0, out_r.decode_status, out_r.payload_length, out_r.payload_byte};

endmodule

// ----- dv/slip_frame_decoder_core_test.sv -----
// Self-checking testbench for the streaming SLIP frame decoder core.
`timescale 1ns / 1ps

module slip_frame_decoder_core_test
  import sfd_pkg::*;
();

  // Tracks the decoder state and the results it owes.
  class slip_decode_tracker;
    logic [15:0] raw_limit;
    logic [1:0]  rx_mode;
    logic [15:0] raw_cnt;
    logic [15:0] payload_cnt;
    bit          esc_seen;
    logic [1:0]  frame_err;
    result_t     owed_results[$];
    int          mismatches;

    function new();
      raw_limit   = MAX_RAW_LENGTH_RESET;
      rx_mode     = MODE_IDLE;
      mismatches  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      raw_cnt     = 16'd0;
      payload_cnt = 16'd0;
      esc_seen    = 1'b0;
      frame_err   = STATUS_OK;
    endfunction

    function void set_limit(logic [15:0] value);
      raw_limit = value;
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    function void owe(logic [1:0] kind, logic [7:0] b, logic [15:0] len, logic [1:0] st);
      result_t r;
      r.kind           = kind;
      r.payload_byte   = b;
      r.payload_length = len;
      r.decode_status  = st;
      owed_results.push_back(r);
    endfunction

    // Advance the decoder by one accepted input item.
    function void take_raw_item(logic op, logic [7:0] b);
      logic [15:0] lim;
      logic [1:0]  st;
      logic [7:0]  d;
      if (op == OP_ARM) begin
        rx_mode = MODE_HUNT;
        clear_frame();
        return;
      end
      if (rx_mode == MODE_HUNT) begin
        if (b == SLIP_END) begin
          rx_mode = MODE_FRAME;
          clear_frame();
          raw_cnt = 16'd1;
        end
        return;
      end
      if (rx_mode != MODE_FRAME) return;
      lim = (raw_limit != 16'd0) ? raw_limit - 16'd1 : 16'd0;
      if (raw_cnt >= lim) begin
        owe(KIND_OVERFLOW, 8'd0, 16'd0, STATUS_OK);
        return;
      end
      raw_cnt = raw_cnt + 16'd1;
      if (b == SLIP_END) begin
        st = frame_err;
        if (st == STATUS_OK && esc_seen) st = STATUS_CUT;
        owe(KIND_END, 8'd0, payload_cnt, st);
        rx_mode  = MODE_IDLE;
        esc_seen = 1'b0;
        return;
      end
      if (frame_err != STATUS_OK) return;
      d = b;
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (b == SLIP_ESC_END) begin
          d = SLIP_END;
        end else if (b == SLIP_ESC_ESC) begin
          d = SLIP_ESC;
        end else begin
          frame_err = STATUS_BAD;
          return;
        end
      end else if (b == SLIP_ESC) begin
        esc_seen = 1'b1;
        return;
      end
      payload_cnt = payload_cnt + 16'd1;
      owe(KIND_BYTE, d, 16'd0, STATUS_OK);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatches++;
    endtask

    task match_result(logic [1:0] kind, logic [31:0] data);
      result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result kind", kind, 0);
        return;
      end
      want = owed_results.pop_front();
      if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
      if (data[7:0] !== want.payload_byte)
        report_mismatch("payload_byte", data[7:0], want.payload_byte);
      if (data[23:8] !== want.payload_length)
        report_mismatch("payload_length", data[23:8], want.payload_length);
      if (data[25:24] !== want.decode_status)
        report_mismatch("decode_status", data[25:24], want.decode_status);
    endtask

    task check_leftovers();
      if (owed_results.size() != 0)
        report_mismatch("results never delivered", owed_results.size(), 0);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] data_byte
  logic        in_tuser = 1'b0;   // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [7:0] payload_byte, [23:8] payload_length,
                                  // [25:24] decode_status
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;  // max_raw_length

  slip_decode_tracker decoder;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int sent_count   = 0;

  slip_frame_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Check accepted results, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) decoder.match_result(out_tuser, out_tdata);
    out_tready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decoder.take_raw_item(op, b);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoder.owed() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_drained();
    // let a resultless item finish
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    decoder.set_limit(value);
  endtask

  // Send one payload byte with proper escaping.
  task automatic send_payload(input logic [7:0] d);
    if (d == SLIP_END) begin
      send_item(OP_DATA, SLIP_ESC);
      send_item(OP_DATA, SLIP_ESC_END);
    end else if (d == SLIP_ESC) begin
      send_item(OP_DATA, SLIP_ESC);
      send_item(OP_DATA, SLIP_ESC_ESC);
    end else begin
      send_item(OP_DATA, d);
    end
  endtask

  task automatic send_random_sequence();
    int r;
    int n;
    logic [7:0] b;
    if ($urandom_range(0, 24) == 0) wait_drained();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: stray bytes and occasional arms
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++)
        send_item(($urandom_range(0, 7) == 0) ? OP_ARM : OP_DATA, 8'($urandom_range(0, 255)));
      return;
    end
    send_item(OP_ARM, 8'($urandom_range(0, 255)));
    n = $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom_range(0, 255));
      if (b == SLIP_END) b = 8'h00;
      send_item(OP_DATA, b);
    end
    send_item(OP_DATA, SLIP_END);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // bad escape
        b = 8'($urandom_range(0, 255));
        if (b == SLIP_ESC_END || b == SLIP_ESC_ESC || b == SLIP_END) b = 8'h00;
        send_item(OP_DATA, SLIP_ESC);
        send_item(OP_DATA, b);
      end else if (r < 10) begin
        send_payload(SLIP_END);
      end else if (r < 17) begin
        send_payload(SLIP_ESC);
      end else if (r < 21) begin
        send_payload(SLIP_ESC_END);
      end else if (r < 25) begin
        send_payload(SLIP_ESC_ESC);
      end else begin
        send_payload(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 85) begin
      send_item(OP_DATA, SLIP_END);
    end else if (r < 92) begin
      send_item(OP_DATA, SLIP_ESC);
      send_item(OP_DATA, SLIP_END);
    end
    // otherwise leave the frame open; the next arm restarts the hunt
    if ($urandom_range(0, 9) == 0) send_item(OP_DATA, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int base;
    logic [15:0] lim;
    decoder = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored bytes, escapes, all status codes, arm mid-frame
    send_item(OP_DATA, 8'hFF);
    send_item(OP_ARM, 8'h00);
    send_item(OP_DATA, 8'h55);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_payload(SLIP_END);
    send_payload(SLIP_ESC);
    send_item(OP_DATA, SLIP_ESC_END);
    send_item(OP_DATA, SLIP_ESC_ESC);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_DATA, 8'hAA);
    send_item(OP_ARM, 8'hFF);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_DATA, SLIP_ESC);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_ARM, 8'h00);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_DATA, 8'h11);
    send_item(OP_DATA, SLIP_ESC);
    send_item(OP_DATA, 8'h41);
    send_item(OP_DATA, 8'h22);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_ARM, 8'h00);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_DATA, 8'h33);
    send_item(OP_ARM, 8'h00);
    send_item(OP_DATA, SLIP_END);
    send_item(OP_DATA, SLIP_END);
    base = sent_count;

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: lim = 16'd256;
        1: lim = 16'd3;
        2: lim = 16'd65535;
        3: lim = 16'd24;
        4: lim = 16'd0;
        5: lim = 16'd1;
        6: lim = 16'd2;
        7: lim = 16'($urandom_range(3, 64));
        8: lim = 16'd10;
        default: lim = 16'($urandom_range(3, 65535));
      endcase
      write_limit(lim);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 56;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 56;
        end
        default: begin
          tx_idle_pct  = 29;
          rx_stall_pct = 29;
        end
      endcase
      while (sent_count < base + (p + 1) * 180) send_random_sequence();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    decoder.check_leftovers();
    if (decoder.mismatches == 0) begin
      $display("slip_frame_decoder_core test passed");
    end else begin
      $display("slip_frame_decoder_core test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("slip_frame_decoder_core test failed");
    $finish;
  end

endmodule
